// ----- sv/fan_group_controller_core_macros.svh -----
// Assertion helpers for the fan group controller checker.
`ifndef FAN_GROUP_CONTROLLER_CORE_MACROS_SVH
`define FAN_GROUP_CONTROLLER_CORE_MACROS_SVH

// Same-cycle implication, clocked on i_clk, off while in reset.
`define FGC_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off while in reset.
`define FGC_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- sv/fgc_pkg.sv -----
package fgc_pkg;

    localparam int REQ_W      = 3;
    localparam int GRP_W      = 2;
    localparam int DUTY_W     = 18;
    localparam int MS_W       = 16;
    localparam int CUR_W      = 16;
    localparam int ST_W       = 2;
    localparam int PULSE_W    = 16;
    localparam int CNT_W      = 16;
    localparam int RPM_W      = 16;
    localparam int DNOW_W     = 17;
    localparam int MASK_W     = 3;
    localparam int PERIOD_W   = 16;
    localparam int SIG_W      = 16;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 16;
    localparam int MAX_RES    = 3;

    // edges * 30000 fits in 31 bits
    localparam int RPM_K_W    = 15;
    localparam int DIVD_W     = CNT_W + RPM_K_W;
    localparam int DIV_STEPS  = DIVD_W;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int PROD_D_W   = DNOW_W + PERIOD_W;

    localparam logic [REQ_W-1:0] REQ_EDGE   = 3'd0;
    localparam logic [REQ_W-1:0] REQ_TICK   = 3'd1;
    localparam logic [REQ_W-1:0] REQ_DUTY   = 3'd2;
    localparam logic [REQ_W-1:0] REQ_OFF    = 3'd3;
    localparam logic [REQ_W-1:0] REQ_HEALTH = 3'd4;

    localparam logic [ST_W-1:0] ST_OK        = 2'd0;
    localparam logic [ST_W-1:0] ST_BAD_GROUP = 2'd1;
    localparam logic [ST_W-1:0] ST_FROZEN    = 2'd2;

    localparam logic [CFG_IDX_W-1:0] CFG_TACH      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_METERED   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PERIOD    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_FROZEN    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_INNER = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_SIG_GUARD = 3'd5;

    localparam logic [GRP_W-1:0] GRP_INNER  = 2'd0;
    localparam logic [GRP_W-1:0] GRP_ALL_OK = 2'd3;

    localparam logic [MASK_W-1:0]   RST_TACH    = 3'd0;
    localparam logic [MASK_W-1:0]   RST_METERED = 3'd3;
    localparam logic [PERIOD_W-1:0] RST_PERIOD  = 16'd4000;

    localparam logic [DNOW_W-1:0]  FULL_Q16   = 17'd65536;
    localparam logic [DNOW_W-1:0]  MIN_DUTY   = 17'd13108;
    localparam logic [RPM_W-1:0]   RPM_STALL  = 16'd60;
    localparam logic [SIG_W-1:0]   SIG_MIN    = 16'd10;
    localparam logic [RPM_K_W-1:0] RPM_K      = 15'd30000;

    typedef struct packed {
        logic load;
        logic edge_upd;
        logic duty_mul;
        logic duty_emit;
        logic off_emit;
        logic health_emit;
        logic idx_inc;
        logic tick_mul;
        logic div_start;
        logic tick_wb;
    } t_cmd;

    typedef struct packed {
        logic ms_zero;
        logic tach_sel;
        logic idx_last;
        logic div_done;
    } t_stat;

endpackage

// ----- sv/fan_group_controller_core.sv -----
// Fan group controller: PWM duty, tach speed and health for up to three groups.
// Requests: an item is taken at a clock edge with start high and busy low.
// Results leave on o_strobe, one cycle each, and cannot be held off.
// A multi-result item (all off) delivers its results on consecutive cycles;
// o_last marks the final one of an item.
// Steps after the accepting edge:
//   tach edge      edge count update, no result
//   set duty       multiply, then emit; result registered onto o_strobe
//   all off        one result per group on back-to-back cycles
//   health query   single emit step, result registered onto o_strobe
//   tick           tach groups: select, multiply, 31-step shift-subtract divide,
//                  write back; other groups select only; nothing when length is 0
// Configuration: i_cfg_we writes register i_cfg_index at the clock edge; the user
// makes writes only while the block is idle, which the block does not enforce.
// Reset (synchronous, active low) clears edge counts, speeds, duties and the
// pending result, and loads the register defaults.
module fan_group_controller_core #(
    parameter int GROUPS = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               start,
    output logic                               busy,
    input  logic [fgc_pkg::REQ_W-1:0]          i_req_type,
    input  logic [fgc_pkg::GRP_W-1:0]          i_group,
    input  logic signed [fgc_pkg::DUTY_W-1:0]  i_duty_q16,
    input  logic [fgc_pkg::MS_W-1:0]           i_tick_ms,
    input  logic [fgc_pkg::CUR_W-1:0]          i_inner_current_ma,
    input  logic [fgc_pkg::CUR_W-1:0]          i_guard_current_ma,
    input  logic                               i_cfg_we,
    input  logic [fgc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fgc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    output logic                               o_strobe,
    output logic [fgc_pkg::ST_W-1:0]           o_status,
    output logic                               o_pwm_write,
    output logic [fgc_pkg::GRP_W-1:0]          o_pwm_group,
    output logic [fgc_pkg::PULSE_W-1:0]        o_pulse_ticks,
    output logic [fgc_pkg::GRP_W-1:0]          o_unhealthy_group,
    output logic                               o_last
);
    import fgc_pkg::*;

    t_cmd  cmd;
    t_stat stat;

    fgc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start),
        .i_req_type (i_req_type),
        .i_stat     (stat),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    fgc_dp #(
        .GROUPS (GROUPS)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_stat             (stat),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .i_group            (i_group),
        .i_duty_q16         (i_duty_q16),
        .i_tick_ms          (i_tick_ms),
        .i_inner_current_ma (i_inner_current_ma),
        .i_guard_current_ma (i_guard_current_ma),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_pwm_write        (o_pwm_write),
        .o_pwm_group        (o_pwm_group),
        .o_pulse_ticks      (o_pulse_ticks),
        .o_unhealthy_group  (o_unhealthy_group),
        .o_last             (o_last)
    );

endmodule

// ----- sv/fgc_div.sv -----
module fgc_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [fgc_pkg::DIVD_W-1:0]  i_dividend,
    input  logic [fgc_pkg::MS_W-1:0]    i_divisor,
    output logic [fgc_pkg::DIVD_W-1:0]  o_quotient,
    output logic                        o_done
);
    import fgc_pkg::*;

    localparam logic [DIV_CNT_W-1:0] LAST_STEP = DIV_CNT_W'(DIV_STEPS - 1);

    logic                 r_run;
    logic                 r_done;
    logic [DIV_CNT_W-1:0] r_cnt;
    logic [MS_W-1:0]      r_rem;
    logic [DIVD_W-1:0]    r_quo;

    logic [MS_W:0]   trial;
    logic [MS_W:0]   diff;
    logic            n_bit;
    logic [MS_W-1:0] n_rem;

    always_comb begin
        trial = {r_rem, r_quo[DIVD_W-1]};
        diff  = trial - {1'b0, i_divisor};
        n_bit = (trial >= {1'b0, i_divisor});
        n_rem = n_bit ? diff[MS_W-1:0] : trial[MS_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_run <= 1'b1;
                r_cnt <= '0;
            end else if (r_run) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == LAST_STEP) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_quo <= i_dividend;
        end else if (r_run) begin
            r_rem <= n_rem;
            r_quo <= {r_quo[DIVD_W-2:0], n_bit};
        end
    end

    assign o_quotient = r_quo;
    assign o_done     = r_done;

endmodule

// ----- sv/fgc_ctrl.sv -----
module fgc_ctrl (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    input  logic [fgc_pkg::REQ_W-1:0]  i_req_type,
    input  fgc_pkg::t_stat             i_stat,
    output fgc_pkg::t_cmd              o_cmd,
    output logic                       o_busy
);
    import fgc_pkg::*;

    localparam logic [3:0] S_IDLE       = 4'd0;
    localparam logic [3:0] S_EDGE       = 4'd1;
    localparam logic [3:0] S_DUTY_MUL   = 4'd2;
    localparam logic [3:0] S_DUTY_OUT   = 4'd3;
    localparam logic [3:0] S_OFF        = 4'd4;
    localparam logic [3:0] S_HEALTH     = 4'd5;
    localparam logic [3:0] S_TICK_SEL   = 4'd6;
    localparam logic [3:0] S_TICK_MUL   = 4'd7;
    localparam logic [3:0] S_TICK_START = 4'd8;
    localparam logic [3:0] S_TICK_WAIT  = 4'd9;

    logic [3:0] r_state;
    logic [3:0] n_state;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.load = 1'b1;
                    unique case (i_req_type)
                        REQ_EDGE:   n_state = S_EDGE;
                        REQ_TICK:   n_state = S_TICK_SEL;
                        REQ_DUTY:   n_state = S_DUTY_MUL;
                        REQ_OFF:    n_state = S_OFF;
                        REQ_HEALTH: n_state = S_HEALTH;
                        default:    n_state = S_IDLE;
                    endcase
                end
            end
            S_EDGE: begin
                o_cmd.edge_upd = 1'b1;
                n_state = S_IDLE;
            end
            S_DUTY_MUL: begin
                o_cmd.duty_mul = 1'b1;
                n_state = S_DUTY_OUT;
            end
            S_DUTY_OUT: begin
                o_cmd.duty_emit = 1'b1;
                n_state = S_IDLE;
            end
            S_OFF: begin
                o_cmd.off_emit = 1'b1;
                if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_HEALTH: begin
                o_cmd.health_emit = 1'b1;
                n_state = S_IDLE;
            end
            S_TICK_SEL: begin
                if (i_stat.ms_zero) begin
                    n_state = S_IDLE;
                end else if (i_stat.tach_sel) begin
                    n_state = S_TICK_MUL;
                end else if (i_stat.idx_last) begin
                    n_state = S_IDLE;
                end else begin
                    o_cmd.idx_inc = 1'b1;
                end
            end
            S_TICK_MUL: begin
                o_cmd.tick_mul = 1'b1;
                n_state = S_TICK_START;
            end
            S_TICK_START: begin
                o_cmd.div_start = 1'b1;
                n_state = S_TICK_WAIT;
            end
            S_TICK_WAIT: begin
                if (i_stat.div_done) begin
                    o_cmd.tick_wb = 1'b1;
                    if (i_stat.idx_last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.idx_inc = 1'b1;
                        n_state = S_TICK_SEL;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    assign o_busy = (r_state != S_IDLE);

endmodule

// ----- sv/fgc_dp.sv -----
module fgc_dp #(
    parameter int GROUPS = 3
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  fgc_pkg::t_cmd                      i_cmd,
    output fgc_pkg::t_stat                     o_stat,
    input  logic                               i_cfg_we,
    input  logic [fgc_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [fgc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata,
    input  logic [fgc_pkg::GRP_W-1:0]          i_group,
    input  logic signed [fgc_pkg::DUTY_W-1:0]  i_duty_q16,
    input  logic [fgc_pkg::MS_W-1:0]           i_tick_ms,
    input  logic [fgc_pkg::CUR_W-1:0]          i_inner_current_ma,
    input  logic [fgc_pkg::CUR_W-1:0]          i_guard_current_ma,
    output logic                               o_strobe,
    output logic [fgc_pkg::ST_W-1:0]           o_status,
    output logic                               o_pwm_write,
    output logic [fgc_pkg::GRP_W-1:0]          o_pwm_group,
    output logic [fgc_pkg::PULSE_W-1:0]        o_pulse_ticks,
    output logic [fgc_pkg::GRP_W-1:0]          o_unhealthy_group,
    output logic                               o_last
);
    import fgc_pkg::*;

    // only the first three groups carry tach or health state; metering covers groups 0 and 1
    localparam int NG = (GROUPS < MAX_RES) ? GROUPS : MAX_RES;

    // configuration
    logic [MASK_W-1:0]   r_tach;
    logic [MASK_W-1:0]   r_metered;
    logic [PERIOD_W-1:0] r_period;
    logic                r_frozen;
    logic [SIG_W-1:0]    r_sig_inner;
    logic [SIG_W-1:0]    r_sig_guard;

    // latched request
    logic [GRP_W-1:0]         r_grp;
    logic signed [DUTY_W-1:0] r_duty;
    logic [MS_W-1:0]          r_ms;
    logic [CUR_W-1:0]         r_cur_inner;
    logic [CUR_W-1:0]         r_cur_guard;

    // per-group state
    logic [CNT_W-1:0]  r_edge  [NG];
    logic [RPM_W-1:0]  r_speed [NG];
    logic              r_known [NG];
    logic [DNOW_W-1:0] r_dnow  [NG];

    logic [GRP_W-1:0]    r_idx;
    logic [DIVD_W-1:0]   r_prod_tick;
    logic [PROD_D_W-1:0] r_prod_duty;

    // result register
    logic               r_strobe;
    logic [ST_W-1:0]    r_status;
    logic               r_wr;
    logic [GRP_W-1:0]   r_pgrp;
    logic [PULSE_W-1:0] r_pulse;
    logic [GRP_W-1:0]   r_unh;
    logic               r_last;

    logic [CNT_W-1:0]  sel_edge;
    logic              sel_tach;
    logic              idx_last;
    logic [DIVD_W-1:0] quotient;
    logic              div_done;
    logic [RPM_W-1:0]  rpm_sat;
    logic [DNOW_W-1:0] duty_cl;
    logic              grp_valid;
    logic              frozen_hit;
    logic              duty_ok;
    logic [ST_W-1:0]   duty_status;
    logic              col_inner;
    logic              col_guard;
    logic [NG-1:0]     h_fail;
    logic [GRP_W-1:0]  h_found;

    always_comb begin
        sel_edge = '0;
        sel_tach = 1'b0;
        for (int g = 0; g < NG; g++) begin
            if (r_idx == GRP_W'(g)) begin
                sel_edge = r_edge[g];
                sel_tach = r_tach[g];
            end
        end
    end

    assign idx_last = (r_idx == GRP_W'(NG - 1));
    assign rpm_sat  = (|quotient[DIVD_W-1:RPM_W]) ? '1 : quotient[RPM_W-1:0];

    assign o_stat.ms_zero  = (r_ms == '0);
    assign o_stat.tach_sel = sel_tach;
    assign o_stat.idx_last = idx_last;
    assign o_stat.div_done = div_done;

    fgc_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.div_start),
        .i_dividend (r_prod_tick),
        .i_divisor  (r_ms),
        .o_quotient (quotient),
        .o_done     (div_done)
    );

    always_comb begin
        if (r_duty[DUTY_W-1]) begin
            duty_cl = '0;
        end else if (r_duty[DNOW_W-1:0] > FULL_Q16) begin
            duty_cl = FULL_Q16;
        end else begin
            duty_cl = r_duty[DNOW_W-1:0];
        end
    end

    assign grp_valid  = (32'(r_grp) < GROUPS);
    assign frozen_hit = (r_grp == GRP_INNER) && r_frozen;
    assign duty_ok    = grp_valid && !frozen_hit;

    always_comb begin
        if (!grp_valid) begin
            duty_status = ST_BAD_GROUP;
        end else if (frozen_hit) begin
            duty_status = ST_FROZEN;
        end else begin
            duty_status = ST_OK;
        end
    end

    // collapsed rail: 5 * current < 4 * signature
    assign col_inner = r_metered[0] && (r_sig_inner > SIG_MIN) &&
        (({r_cur_inner, 2'b00} + {2'b00, r_cur_inner}) < {1'b0, r_sig_inner, 2'b00});
    assign col_guard = r_metered[1] && (r_sig_guard > SIG_MIN) &&
        (({r_cur_guard, 2'b00} + {2'b00, r_cur_guard}) < {1'b0, r_sig_guard, 2'b00});

    always_comb begin
        for (int g = 0; g < NG; g++) begin
            h_fail[g] = (r_dnow[g] >= MIN_DUTY) &&
                ((r_tach[g] && r_known[g] && (r_speed[g] < RPM_STALL)) ||
                 ((g == 0) && col_inner) || ((g == 1) && col_guard));
        end
        h_found = GRP_ALL_OK;
        for (int g = NG - 1; g >= 0; g--) begin
            if (h_fail[g]) begin
                h_found = GRP_W'(g);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tach      <= RST_TACH;
            r_metered   <= RST_METERED;
            r_period    <= RST_PERIOD;
            r_frozen    <= 1'b0;
            r_sig_inner <= '0;
            r_sig_guard <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_TACH:      r_tach      <= i_cfg_wdata[MASK_W-1:0];
                CFG_METERED:   r_metered   <= i_cfg_wdata[MASK_W-1:0];
                CFG_PERIOD:    r_period    <= i_cfg_wdata[PERIOD_W-1:0];
                CFG_FROZEN:    r_frozen    <= i_cfg_wdata[0];
                CFG_SIG_INNER: r_sig_inner <= i_cfg_wdata[SIG_W-1:0];
                CFG_SIG_GUARD: r_sig_guard <= i_cfg_wdata[SIG_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_grp       <= i_group;
            r_duty      <= i_duty_q16;
            r_ms        <= i_tick_ms;
            r_cur_inner <= i_inner_current_ma;
            r_cur_guard <= i_guard_current_ma;
        end
        if (i_cmd.tick_mul) begin
            r_prod_tick <= {{RPM_K_W{1'b0}}, sel_edge} * {{CNT_W{1'b0}}, RPM_K};
        end
        if (i_cmd.duty_mul) begin
            r_prod_duty <= {{PERIOD_W{1'b0}}, duty_cl} * {{DNOW_W{1'b0}}, r_period};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
            for (int g = 0; g < NG; g++) begin
                r_edge[g]  <= '0;
                r_speed[g] <= '0;
                r_known[g] <= 1'b0;
                r_dnow[g]  <= '0;
            end
        end else begin
            if (i_cmd.load) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            for (int g = 0; g < NG; g++) begin
                if (i_cmd.edge_upd && (r_grp == GRP_W'(g)) && r_tach[g] &&
                    (r_edge[g] != '1)) begin
                    r_edge[g] <= r_edge[g] + 1'b1;
                end
                if (i_cmd.tick_wb && (r_idx == GRP_W'(g))) begin
                    r_speed[g] <= rpm_sat;
                    r_known[g] <= 1'b1;
                    r_edge[g]  <= '0;
                end
                if (i_cmd.duty_mul && duty_ok && (r_grp == GRP_W'(g))) begin
                    r_dnow[g] <= duty_cl;
                end
                if (i_cmd.off_emit && (r_idx == GRP_W'(g))) begin
                    r_dnow[g] <= '0;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_strobe <= 1'b0;
        end else begin
            r_strobe <= i_cmd.duty_emit || i_cmd.off_emit || i_cmd.health_emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.duty_emit) begin
            r_status <= duty_status;
            r_wr     <= duty_ok;
            r_pgrp   <= duty_ok ? r_grp : '0;
            r_pulse  <= duty_ok ? r_prod_duty[PULSE_W+15:16] : '0;
            r_unh    <= '0;
            r_last   <= 1'b1;
        end else if (i_cmd.off_emit) begin
            r_status <= ST_OK;
            r_wr     <= 1'b1;
            r_pgrp   <= r_idx;
            r_pulse  <= '0;
            r_unh    <= '0;
            r_last   <= idx_last;
        end else if (i_cmd.health_emit) begin
            r_status <= ST_OK;
            r_wr     <= 1'b0;
            r_pgrp   <= '0;
            r_pulse  <= '0;
            r_unh    <= h_found;
            r_last   <= 1'b1;
        end
    end

    assign o_strobe          = r_strobe;
    assign o_status          = r_status;
    assign o_pwm_write       = r_wr;
    assign o_pwm_group       = r_pgrp;
    assign o_pulse_ticks     = r_pulse;
    assign o_unhealthy_group = r_unh;
    assign o_last            = r_last;

endmodule

// ----- sv/fgc_checker.sv -----
`include "fan_group_controller_core_macros.svh"

module fgc_checker (
    input logic                       i_clk,
    input logic                       i_rst_n,
    input logic                       start,
    input logic                       busy,
    input logic [fgc_pkg::REQ_W-1:0]  i_req_type,
    input logic                       o_strobe,
    input logic [fgc_pkg::ST_W-1:0]   o_status,
    input logic                       o_pwm_write,
    input logic                       o_last
);
    import fgc_pkg::*;

    `FGC_ASSERT_NEXT(a_accept_busy, start && !busy && (i_req_type <= REQ_HEALTH), busy, "known request did not raise busy")
    `FGC_ASSERT_NOW(a_write_ok, o_strobe && o_pwm_write, o_status == ST_OK, "pulse written with error status")
    `FGC_ASSERT_NEXT(a_burst, o_strobe && !o_last, o_strobe, "gap inside a multi-result transfer")
    `FGC_ASSERT_NEXT(a_gap, o_strobe && o_last, !o_strobe, "result right after final result")

endmodule

bind fan_group_controller_core fgc_checker u_fgc_checker (.*);

// ----- tb/fan_group_controller_core_tb.sv -----
`timescale 1ns / 1ps

module fan_group_controller_core_tb;

    import fgc_pkg::*;

    localparam int NGRP        = 3;
    localparam int DRAIN       = 150;
    localparam int CYCLE_LIMIT = 1_000_000;
    localparam int DUTY_ONE    = 65536;
    localparam int DUTY_JUDGE  = 13108;
    localparam int STALL_RPM   = 60;
    localparam int SIG_FLOOR   = 10;
    localparam int RPM_PER_EDGE_MS = 30000;

    typedef struct {
        logic [REQ_W-1:0]         kind;
        logic [GRP_W-1:0]         grp;
        logic signed [DUTY_W-1:0] duty;
        logic [MS_W-1:0]          ms;
        logic [CUR_W-1:0]         inner_ma;
        logic [CUR_W-1:0]         guard_ma;
    } t_fan_req;

    typedef struct {
        logic [ST_W-1:0]    status;
        logic               pwm_write;
        logic [GRP_W-1:0]   pwm_group;
        logic [PULSE_W-1:0] pulse;
        logic [GRP_W-1:0]   unhealthy;
        logic               last;
    } t_fan_resp;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic start;
    logic busy;
    logic [REQ_W-1:0] i_req_type;
    logic [GRP_W-1:0] i_group;
    logic signed [DUTY_W-1:0] i_duty_q16;
    logic [MS_W-1:0] i_tick_ms;
    logic [CUR_W-1:0] i_inner_current_ma;
    logic [CUR_W-1:0] i_guard_current_ma;
    logic i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_wdata;
    logic o_strobe;
    logic [ST_W-1:0] o_status;
    logic o_pwm_write;
    logic [GRP_W-1:0] o_pwm_group;
    logic [PULSE_W-1:0] o_pulse_ticks;
    logic [GRP_W-1:0] o_unhealthy_group;
    logic o_last;

    // shadow of the block's registers and state
    logic [MASK_W-1:0]   tach_mask;
    logic [MASK_W-1:0]   meter_mask;
    logic [PERIOD_W-1:0] period;
    logic                frozen;
    logic [SIG_W-1:0]    sig_inner;
    logic [SIG_W-1:0]    sig_guard;
    logic [CNT_W-1:0]    edges [NGRP];
    logic [RPM_W-1:0]    rpm [NGRP];
    logic                rpm_valid [NGRP];
    logic [DNOW_W-1:0]   duty_set [NGRP];

    t_fan_resp responses_due [$];
    int faults = 0;
    int cycles = 0;
    bit gaps_on = 1'b1;

    fan_group_controller_core uut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .start              (start),
        .busy               (busy),
        .i_req_type         (i_req_type),
        .i_group            (i_group),
        .i_duty_q16         (i_duty_q16),
        .i_tick_ms          (i_tick_ms),
        .i_inner_current_ma (i_inner_current_ma),
        .i_guard_current_ma (i_guard_current_ma),
        .i_cfg_we           (i_cfg_we),
        .i_cfg_index        (i_cfg_index),
        .i_cfg_wdata        (i_cfg_wdata),
        .o_strobe           (o_strobe),
        .o_status           (o_status),
        .o_pwm_write        (o_pwm_write),
        .o_pwm_group        (o_pwm_group),
        .o_pulse_ticks      (o_pulse_ticks),
        .o_unhealthy_group  (o_unhealthy_group),
        .o_last             (o_last)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("fan_group_controller_core: mismatch");
            $finish;
        end
    end

    function automatic void reset_model();
        int i;
        tach_mask  = RST_TACH;
        meter_mask = RST_METERED;
        period     = RST_PERIOD;
        frozen     = 1'b0;
        sig_inner  = '0;
        sig_guard  = '0;
        for (i = 0; i < NGRP; i++) begin
            edges[i]     = '0;
            rpm[i]       = '0;
            rpm_valid[i] = 1'b0;
            duty_set[i]  = '0;
        end
    endfunction

    // Updates the shadow state for one accepted request and queues its results.
    function automatic void compute_fan_response(input t_fan_req r);
        t_fan_resp res;
        logic [63:0] speed;
        logic [DNOW_W-1:0] duty;
        logic [32:0] prod;
        logic [GRP_W-1:0] hit;
        logic [31:0] sig;
        logic [31:0] draw;
        int i;
        res = '{default: '0};
        case (r.kind)
            REQ_EDGE: begin
                if (r.grp < NGRP && tach_mask[r.grp] && edges[r.grp] != 16'hFFFF)
                    edges[r.grp]++;
            end
            REQ_TICK: begin
                if (r.ms != 0) begin
                    for (i = 0; i < NGRP; i++) begin
                        if (tach_mask[i]) begin
                            speed = 64'(edges[i]) * 64'(RPM_PER_EDGE_MS) / 64'(r.ms);
                            rpm[i] = (speed > 64'hFFFF) ? 16'hFFFF : speed[15:0];
                            rpm_valid[i] = 1'b1;
                            edges[i] = '0;
                        end
                    end
                end
            end
            REQ_DUTY: begin
                res.last = 1'b1;
                if (r.grp >= NGRP) begin
                    res.status = ST_BAD_GROUP;
                end else if (r.grp == GRP_INNER && frozen) begin
                    res.status = ST_FROZEN;
                end else begin
                    if (r.duty[DUTY_W-1])
                        duty = '0;
                    else if (r.duty > DUTY_ONE)
                        duty = DNOW_W'(DUTY_ONE);
                    else
                        duty = r.duty[DNOW_W-1:0];
                    duty_set[r.grp] = duty;
                    prod = 33'(duty) * 33'(period);
                    res.status = ST_OK;
                    res.pwm_write = 1'b1;
                    res.pwm_group = r.grp;
                    res.pulse = prod[31:16];
                end
                responses_due.push_back(res);
            end
            REQ_OFF: begin
                for (i = 0; i < NGRP; i++) begin
                    duty_set[i] = '0;
                    res.status = ST_OK;
                    res.pwm_write = 1'b1;
                    res.pwm_group = GRP_W'(i);
                    res.pulse = '0;
                    res.last = (i == NGRP - 1);
                    responses_due.push_back(res);
                end
            end
            REQ_HEALTH: begin
                hit = GRP_ALL_OK;
                for (i = 0; i < NGRP; i++) begin
                    if (duty_set[i] < DUTY_JUDGE)
                        continue;
                    if (tach_mask[i] && rpm_valid[i] && rpm[i] < STALL_RPM) begin
                        hit = GRP_W'(i);
                        break;
                    end
                    if (i > 1 || !meter_mask[i])
                        continue;
                    sig  = (i == 0) ? 32'(sig_inner) : 32'(sig_guard);
                    draw = (i == 0) ? 32'(r.inner_ma) : 32'(r.guard_ma);
                    if (sig > SIG_FLOOR && 5 * draw < 4 * sig) begin
                        hit = GRP_W'(i);
                        break;
                    end
                end
                res.unhealthy = hit;
                res.last = 1'b1;
                responses_due.push_back(res);
            end
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            faults++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_fan_resp want;
        if (i_rst_n === 1'b1 && o_strobe === 1'b1) begin
            if (responses_due.size() == 0) begin
                $error("result with no transfer pending: status %0d group %0d pulse %0d",
                       o_status, o_pwm_group, o_pulse_ticks);
                faults++;
            end else begin
                want = responses_due.pop_front();
                check_field("status", want.status, o_status);
                check_field("pwm_write", want.pwm_write, o_pwm_write);
                check_field("pwm_group", want.pwm_group, o_pwm_group);
                check_field("pulse_ticks", want.pulse, o_pulse_ticks);
                check_field("unhealthy_group", want.unhealthy, o_unhealthy_group);
                check_field("last", want.last, o_last);
            end
        end
    end

    function automatic t_fan_req make_request(input logic [REQ_W-1:0] kind,
                                              input logic [GRP_W-1:0] grp,
                                              input logic signed [DUTY_W-1:0] duty,
                                              input logic [MS_W-1:0] ms,
                                              input logic [CUR_W-1:0] inner_ma,
                                              input logic [CUR_W-1:0] guard_ma);
        t_fan_req r;
        r.kind = kind;
        r.grp = grp;
        r.duty = duty;
        r.ms = ms;
        r.inner_ma = inner_ma;
        r.guard_ma = guard_ma;
        return r;
    endfunction

    task automatic issue_request(input t_fan_req r);
        while (gaps_on && $urandom_range(99) < 20) begin
            @(negedge i_clk);
            start = 1'b0;
            i_req_type = REQ_W'($urandom);
            i_group = GRP_W'($urandom);
            i_duty_q16 = DUTY_W'($urandom);
            i_tick_ms = MS_W'($urandom);
            i_inner_current_ma = CUR_W'($urandom);
            i_guard_current_ma = CUR_W'($urandom);
        end
        @(negedge i_clk);
        i_req_type = r.kind;
        i_group = r.grp;
        i_duty_q16 = r.duty;
        i_tick_ms = r.ms;
        i_inner_current_ma = r.inner_ma;
        i_guard_current_ma = r.guard_ma;
        start = 1'b1;
        @(posedge i_clk);
        while (busy !== 1'b0)
            @(posedge i_clk);
        compute_fan_response(r);
    endtask

    task automatic hold_until_drained();
        @(negedge i_clk);
        start = 1'b0;
        while (responses_due.size() != 0)
            @(posedge i_clk);
    endtask

    // tick and edge transfers give no result, so allow the divider time to finish
    task automatic settle_block();
        hold_until_drained();
        repeat (DRAIN) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_wdata = val;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            CFG_TACH:      tach_mask = val[MASK_W-1:0];
            CFG_METERED:   meter_mask = val[MASK_W-1:0];
            CFG_PERIOD:    period = val[PERIOD_W-1:0];
            CFG_FROZEN:    frozen = val[0];
            CFG_SIG_INNER: sig_inner = val[SIG_W-1:0];
            CFG_SIG_GUARD: sig_guard = val[SIG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic test_defaults();
        settle_block();
        issue_request(make_request(REQ_DUTY, 2'd0, 18'sd65536, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd1, 18'sd131071, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd2, -18'sd131072, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd1, 18'sd65535, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd0, 18'sd65537, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        issue_request(make_request(REQ_DUTY, 2'd3, 18'sd30000, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd2, 18'sd1, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd0, -18'sd1, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_EDGE, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_TICK, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_TICK, 2'd3, 18'sd0, 16'hFFFF, 16'd0, 16'd0));
        issue_request(make_request(3'd5, 2'd1, 18'sd100, 16'd10, 16'd5, 16'd5));
        issue_request(make_request(3'd6, 2'd2, 18'sd100, 16'd10, 16'd5, 16'd5));
        issue_request(make_request(3'd7, 2'd3, -18'sd1, 16'hFFFF, 16'hFFFF, 16'hFFFF));
        issue_request(make_request(REQ_HEALTH, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_OFF, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_HEALTH, 2'd3, 18'sd0, 16'd0, 16'hFFFF, 16'hFFFF));
    endtask

    task automatic test_freeze_and_period();
        settle_block();
        write_reg(CFG_FROZEN, 16'd1);
        write_reg(CFG_PERIOD, 16'hFFFF);
        issue_request(make_request(REQ_DUTY, 2'd0, 18'sd40000, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd1, 18'sd65536, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd2, 18'sd32768, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_OFF, 2'd3, 18'sd0, 16'd0, 16'd0, 16'd0));
        settle_block();
        write_reg(CFG_PERIOD, 16'd0);
        issue_request(make_request(REQ_DUTY, 2'd2, 18'sd65536, 16'd0, 16'd0, 16'd0));
        settle_block();
        write_reg(CFG_PERIOD, 16'd1);
        issue_request(make_request(REQ_DUTY, 2'd1, 18'sd65536, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd1, 18'sd65535, 16'd0, 16'd0, 16'd0));
        settle_block();
        write_reg(CFG_FROZEN, 16'd0);
        write_reg(CFG_PERIOD, 16'd4000);
        issue_request(make_request(REQ_DUTY, 2'd0, 18'sd20000, 16'd0, 16'd0, 16'd0));
    endtask

    task automatic test_speed_and_stall();
        settle_block();
        write_reg(CFG_TACH, 16'd7);
        issue_request(make_request(REQ_DUTY, 2'd0, 18'sd32768, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd1, 18'sd13108, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_DUTY, 2'd2, 18'sd13107, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_EDGE, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_TICK, 2'd0, 18'sd0, 16'hFFFF, 16'd0, 16'd0));
        issue_request(make_request(REQ_HEALTH, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
        // speed above range saturates
        repeat (3) issue_request(make_request(REQ_EDGE, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_TICK, 2'd0, 18'sd0, 16'd1, 16'd0, 16'd0));
        issue_request(make_request(REQ_HEALTH, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
        // exactly at the stall threshold is not a stall
        issue_request(make_request(REQ_EDGE, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_EDGE, 2'd1, 18'sd0, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_EDGE, 2'd3, 18'sd0, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_TICK, 2'd0, 18'sd0, 16'd500, 16'd0, 16'd0));
        issue_request(make_request(REQ_HEALTH, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
    endtask

    task automatic test_rail_current();
        settle_block();
        write_reg(CFG_TACH, 16'd0);
        write_reg(CFG_METERED, 16'd7);
        write_reg(CFG_SIG_INNER, 16'd11);
        write_reg(CFG_SIG_GUARD, 16'd10);
        issue_request(make_request(REQ_HEALTH, 2'd0, 18'sd0, 16'd0, 16'd8, 16'd0));
        issue_request(make_request(REQ_HEALTH, 2'd0, 18'sd0, 16'd0, 16'd9, 16'd0));
        settle_block();
        write_reg(CFG_SIG_GUARD, 16'hFFFF);
        issue_request(make_request(REQ_HEALTH, 2'd1, 18'sd0, 16'd0, 16'd9, 16'd52427));
        issue_request(make_request(REQ_HEALTH, 2'd1, 18'sd0, 16'd0, 16'd9, 16'd52428));
        settle_block();
        write_reg(CFG_METERED, 16'd4);
        issue_request(make_request(REQ_HEALTH, 2'd2, 18'sd0, 16'd0, 16'd0, 16'd0));
        settle_block();
        write_reg(CFG_METERED, 16'd1);
        write_reg(CFG_SIG_INNER, 16'hFFFF);
        issue_request(make_request(REQ_HEALTH, 2'd0, 18'sd0, 16'd0, 16'd0, 16'd0));
        issue_request(make_request(REQ_HEALTH, 2'd0, 18'sd0, 16'd0, 16'hFFFF, 16'd0));
    endtask

    function automatic logic signed [DUTY_W-1:0] random_duty();
        case ($urandom_range(3))
            0: return DUTY_W'($urandom);
            1: return DUTY_W'($urandom_range(0, DUTY_ONE));
            2: return DUTY_W'($urandom_range(DUTY_JUDGE - 8, DUTY_JUDGE + 8));
            default: return DUTY_W'(DUTY_ONE - 1 + $urandom_range(2)) ^
                            ($urandom_range(3) == 0 ? {DUTY_W{1'b1}} : '0);
        endcase
    endfunction

    function automatic logic [CUR_W-1:0] random_current(input logic [SIG_W-1:0] sig);
        if ($urandom_range(2) == 0)
            return CUR_W'($urandom);
        return CUR_W'(32'(sig) * 4 / 5 + $urandom_range(4) - 2);
    endfunction

    function automatic logic [15:0] pick_wide();
        case ($urandom_range(4))
            0: return 16'd0;
            1: return 16'd1;
            2: return 16'hFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic t_fan_req random_request(input logic [REQ_W-1:0] kind,
                                                input logic [GRP_W-1:0] grp);
        return make_request(kind, grp, random_duty(),
                            ($urandom_range(9) == 0) ? MS_W'($urandom)
                                                     : MS_W'($urandom_range(1, 3000)),
                            random_current(sig_inner), random_current(sig_guard));
    endfunction

    task automatic run_random_phase(input int n_items, input bit quiet);
        int sent;
        int sel;
        int k;
        gaps_on = !quiet;
        sent = 0;
        while (sent < n_items) begin
            sel = $urandom_range(99);
            if (sel < 40) begin
                k = $urandom_range(6);
                repeat (k) begin
                    issue_request(random_request(REQ_EDGE,
                        ($urandom_range(9) == 0) ? GRP_W'($urandom) : GRP_W'($urandom_range(2))));
                    sent++;
                end
                issue_request(random_request(REQ_TICK, GRP_W'($urandom)));
                sent++;
            end else if (sel < 70) begin
                issue_request(random_request(REQ_DUTY,
                    ($urandom_range(7) == 0) ? 2'd3 : GRP_W'($urandom_range(2))));
                issue_request(random_request(REQ_HEALTH, GRP_W'($urandom)));
                sent += 2;
            end else if (sel < 78) begin
                issue_request(random_request(REQ_OFF, GRP_W'($urandom)));
                sent++;
            end else if (sel < 88) begin
                issue_request(random_request(REQ_HEALTH, GRP_W'($urandom)));
                sent++;
            end else if (sel < 93) begin
                hold_until_drained();
                issue_request(random_request(REQ_HEALTH, GRP_W'($urandom)));
                sent++;
            end else begin
                issue_request(make_request(REQ_W'($urandom), GRP_W'($urandom), DUTY_W'($urandom),
                                           MS_W'($urandom), CUR_W'($urandom), CUR_W'($urandom)));
                sent++;
            end
        end
        gaps_on = 1'b1;
    endtask

    task automatic test_random_traffic();
        int phase;
        for (phase = 0; phase < 6; phase++) begin
            settle_block();
            write_reg(CFG_TACH, ($urandom_range(3) == 0) ? 16'($urandom_range(7)) : 16'd7);
            write_reg(CFG_METERED, 16'($urandom_range(7)));
            write_reg(CFG_PERIOD, ($urandom_range(2) == 0) ? 16'd4000 : pick_wide());
            write_reg(CFG_FROZEN, 16'($urandom_range(1)));
            write_reg(CFG_SIG_INNER, ($urandom_range(1) == 0) ? 16'($urandom_range(40))
                                                             : pick_wide());
            write_reg(CFG_SIG_GUARD, ($urandom_range(1) == 0) ? 16'($urandom_range(40))
                                                             : pick_wide());
            run_random_phase(18, phase == 2);
        end
    endtask

    initial begin
        i_rst_n = 1'b0;
        start = 1'b0;
        i_req_type = REQ_EDGE;
        i_group = '0;
        i_duty_q16 = '0;
        i_tick_ms = '0;
        i_inner_current_ma = '0;
        i_guard_current_ma = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = CFG_TACH;
        i_cfg_wdata = '0;
        reset_model();
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_defaults();
        test_freeze_and_period();
        test_speed_and_stall();
        test_rail_current();
        test_random_traffic();

        settle_block();
        if (responses_due.size() != 0) begin
            $error("%0d expected results never arrived", responses_due.size());
            faults++;
        end
        if (faults == 0) begin
            $display("fan_group_controller_core: match");
        end else begin
            $display("fan_group_controller_core: mismatch");
        end
        $finish;
    end

endmodule

// ----- fan_group_controller_core.f -----
+incdir+sv
sv/fgc_pkg.sv
sv/fgc_div.sv
sv/fgc_ctrl.sv
sv/fgc_dp.sv
sv/fan_group_controller_core.sv
sv/fgc_checker.sv
tb/fan_group_controller_core_tb.sv
